@@ rtl/edb_pkg.sv @@
// edb_pkg: widths, status codes, shared types and the block scaling function
// for the edge dihedral bending core; no dependencies
package edb_pkg;

  localparam int COORD_W     = 32;
  localparam int DIFF_W      = COORD_W + 1;
  localparam int NORM_BITS   = 30;
  localparam int NRM_W       = NORM_BITS + 1;
  localparam int PROD_W      = 2 * NRM_W;
  localparam int WIDE_W      = 64;
  localparam int UNIT_FRAC   = 30;
  localparam int SIGN_SHIFT  = 31;
  localparam int Q_SHIFT     = 17;
  localparam int ROOT_W      = WIDE_W / 2;
  localparam int SQRT_STAGES = ROOT_W;
  localparam int QUO_W       = 33;
  localparam int DEN_W       = 33;
  localparam int DIV_STAGES  = QUO_W;
  localparam int UA_W        = 32;
  localparam int VAL_W       = 32;
  localparam int ST_W        = 2;

  localparam logic [ST_W-1:0] ST_OK    = 2'd0;
  localparam logic [ST_W-1:0] ST_SAT   = 2'd1;
  localparam logic [ST_W-1:0] ST_DEGEN = 2'd2;

  localparam logic [VAL_W-1:0] VAL_MAX = {1'b0, {(VAL_W-1){1'b1}}};
  localparam logic [VAL_W-1:0] VAL_MIN = {1'b1, {(VAL_W-1){1'b0}}};

  typedef logic [COORD_W-1:0] coord_t;
  typedef logic [2:0][WIDE_W-1:0] wvec_t;
  typedef logic [2:0][NRM_W-1:0] nvec_t;

  typedef struct packed {
    coord_t end_a_x;
    coord_t end_a_y;
    coord_t end_a_z;
    coord_t end_b_x;
    coord_t end_b_y;
    coord_t end_b_z;
    coord_t opp_first_x;
    coord_t opp_first_y;
    coord_t opp_first_z;
    coord_t opp_second_x;
    coord_t opp_second_y;
    coord_t opp_second_z;
  } in_item_t;

  typedef struct packed {
    logic              valid;
    nvec_t             nn;
    nvec_t             ntn;
    logic [WIDE_W-1:0] la2;
    logic [WIDE_W-1:0] lb2;
    logic              degen;
    logic              neg;
  } front_t;

  // scale by a power of two so the largest magnitude lands in [2^29, 2^30)
  function automatic nvec_t edb_block_norm(input wvec_t v);
    logic signed [WIDE_W-1:0] x;
    logic [WIDE_W-1:0]        ax;
    logic [WIDE_W-1:0]        mx;
    int                       len;
    nvec_t                    r;
    mx = '0;
    for (int i = 0; i < 3; i++) begin
      x  = v[i];
      ax = x[WIDE_W-1] ? WIDE_W'(-x) : WIDE_W'(x);
      if (ax > mx) mx = ax;
    end
    len = 0;
    for (int b = 0; b < WIDE_W; b++) begin
      if (mx[b]) len = b + 1;
    end
    for (int i = 0; i < 3; i++) begin
      x = v[i];
      if (len > NORM_BITS) x = x >>> (len - NORM_BITS);
      else x = x <<< (NORM_BITS - len);
      r[i] = x[NRM_W-1:0];
    end
    return r;
  endfunction

endpackage

@@ rtl/edb_in_if.sv @@
// edb_in_if: input channel carrying the four vertices of one edge
// depends on edb_pkg
interface edb_in_if import edb_pkg::*; ();
  logic   valid;
  logic   ready;
  coord_t end_a_x;
  coord_t end_a_y;
  coord_t end_a_z;
  coord_t end_b_x;
  coord_t end_b_y;
  coord_t end_b_z;
  coord_t opp_first_x;
  coord_t opp_first_y;
  coord_t opp_first_z;
  coord_t opp_second_x;
  coord_t opp_second_y;
  coord_t opp_second_z;

  modport source (
    output valid, end_a_x, end_a_y, end_a_z, end_b_x, end_b_y, end_b_z,
    output opp_first_x, opp_first_y, opp_first_z,
    output opp_second_x, opp_second_y, opp_second_z,
    input  ready
  );
  modport sink (
    input  valid, end_a_x, end_a_y, end_a_z, end_b_x, end_b_y, end_b_z,
    input  opp_first_x, opp_first_y, opp_first_z,
    input  opp_second_x, opp_second_y, opp_second_z,
    output ready
  );
endinterface

@@ rtl/edb_out_if.sv @@
// edb_out_if: result channel carrying bending value and status
// depends on edb_pkg
interface edb_out_if import edb_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic signed [VAL_W-1:0] bend_value;
  logic [ST_W-1:0]         bend_status;

  modport source (output valid, bend_value, bend_status, input ready);
  modport sink (input valid, bend_value, bend_status, output ready);
endinterface

@@ rtl/edb_isqrt.sv @@
// edb_isqrt: pipelined integer square root, one root bit per stage
// depends on edb_pkg
module edb_isqrt import edb_pkg::*; (
  input  logic              clk,
  input  logic              adv,
  input  logic [WIDE_W-1:0] radicand,
  output logic [ROOT_W-1:0] root
);

  localparam int REM_W = ROOT_W + 3;

  logic [REM_W-1:0]  rem_r  [SQRT_STAGES];
  logic [ROOT_W-1:0] root_r [SQRT_STAGES];
  logic [WIDE_W-1:0] rad_r  [SQRT_STAGES];
  logic [REM_W-1:0]  rem_i  [SQRT_STAGES];
  logic [ROOT_W-1:0] root_i [SQRT_STAGES];
  logic [WIDE_W-1:0] rad_i  [SQRT_STAGES];

  assign rem_i[0]  = '0;
  assign root_i[0] = '0;
  assign rad_i[0]  = radicand;

  for (genvar k = 1; k < SQRT_STAGES; k++) begin : g_link
    assign rem_i[k]  = rem_r[k-1];
    assign root_i[k] = root_r[k-1];
    assign rad_i[k]  = rad_r[k-1];
  end

  for (genvar k = 0; k < SQRT_STAGES; k++) begin : g_stage
    logic [REM_W-1:0] cur;
    logic [REM_W-1:0] trial;
    logic             ge;
    assign cur   = {rem_i[k][ROOT_W:0], rad_i[k][WIDE_W-1 -: 2]};
    assign trial = {1'b0, root_i[k], 2'b01};
    assign ge    = cur >= trial;
    always_ff @(posedge clk) begin
      if (adv) begin
        rem_r[k]  <= ge ? cur - trial : cur;
        root_r[k] <= {root_i[k][ROOT_W-2:0], ge};
        rad_r[k]  <= {rad_i[k][WIDE_W-3:0], 2'b00};
      end
    end
  end

  assign root = root_r[SQRT_STAGES-1];

endmodule

@@ rtl/edb_div.sv @@
// edb_div: pipelined restoring divider, one quotient bit per stage, with
// overflow flag when the quotient needs more than QUO_W bits; depends on edb_pkg
module edb_div import edb_pkg::*; (
  input  logic              clk,
  input  logic              adv,
  input  logic [WIDE_W-1:0] num,
  input  logic [DEN_W-1:0]  den,
  output logic [QUO_W-1:0]  quo,
  output logic              ovf
);

  localparam int HI_W = WIDE_W - QUO_W;

  logic [DEN_W-1:0] rem_r [DIV_STAGES];
  logic [QUO_W-1:0] low_r [DIV_STAGES];
  logic [QUO_W-1:0] quo_r [DIV_STAGES];
  logic [DEN_W-1:0] den_r [DIV_STAGES];
  logic             ovf_r [DIV_STAGES];
  logic [DEN_W-1:0] rem_i [DIV_STAGES];
  logic [QUO_W-1:0] low_i [DIV_STAGES];
  logic [QUO_W-1:0] quo_i [DIV_STAGES];
  logic [DEN_W-1:0] den_i [DIV_STAGES];
  logic             ovf_i [DIV_STAGES];

  assign rem_i[0] = {{(DEN_W-HI_W){1'b0}}, num[WIDE_W-1:QUO_W]};
  assign low_i[0] = num[QUO_W-1:0];
  assign quo_i[0] = '0;
  assign den_i[0] = den;
  assign ovf_i[0] = {{(DEN_W-HI_W){1'b0}}, num[WIDE_W-1:QUO_W]} >= den;

  for (genvar k = 1; k < DIV_STAGES; k++) begin : g_link
    assign rem_i[k] = rem_r[k-1];
    assign low_i[k] = low_r[k-1];
    assign quo_i[k] = quo_r[k-1];
    assign den_i[k] = den_r[k-1];
    assign ovf_i[k] = ovf_r[k-1];
  end

  for (genvar k = 0; k < DIV_STAGES; k++) begin : g_stage
    logic [DEN_W:0] cur;
    logic [DEN_W:0] dext;
    logic [DEN_W:0] diff;
    logic           ge;
    assign cur  = {rem_i[k], low_i[k][QUO_W-1]};
    assign dext = {1'b0, den_i[k]};
    assign ge   = cur >= dext;
    assign diff = cur - dext;
    always_ff @(posedge clk) begin
      if (adv) begin
        rem_r[k] <= ge ? diff[DEN_W-1:0] : cur[DEN_W-1:0];
        low_r[k] <= {low_i[k][QUO_W-2:0], 1'b0};
        quo_r[k] <= {quo_i[k][QUO_W-2:0], ge};
        den_r[k] <= den_i[k];
        ovf_r[k] <= ovf_i[k];
      end
    end
  end

  assign quo = quo_r[DIV_STAGES-1];
  assign ovf = ovf_r[DIV_STAGES-1];

endmodule

@@ rtl/edb_front.sv @@
// edb_front: edge vectors, block scaling, face normals, squared lengths and
// fold sign test in nine register stages; depends on edb_pkg
module edb_front import edb_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     adv,
  input  logic     in_valid,
  input  in_item_t in_item,
  output front_t   front
);

  logic [2:0][COORD_W-1:0] pa, pb, pf, ps;

  logic                    va_r, vb_r, vc_r, vd_r, ve_r, vf_r, vg_r, vh_r, vi_r;
  logic [2:0][DIFF_W-1:0]  e0_r, e1_r, et_r;
  nvec_t                   e0b_r, e1b_r, etb_r;
  nvec_t                   e0c_r, e0d_r, e0e_r, e0f_r, e0g_r;
  logic [2:0][1:0][PROD_W-1:0] pn_r, pt_r, pc_r;
  logic [2:0][PROD_W-1:0]  n_r, nt_r, c_r, sp_r;
  nvec_t                   nne_r, ntne_r, nnf_r, ntnf_r, nng_r, ntng_r;
  nvec_t                   nnh_r, ntnh_r, nni_r, ntni_r;
  logic                    dge_r, dgf_r, dgg_r, dgh_r, dgi_r;
  logic [2:0][PROD_W-1:0]  sqn_r, sqt_r;
  logic [WIDE_W-1:0]       la2g_r, lb2g_r, la2h_r, lb2h_r, la2i_r, lb2i_r;
  logic                    negi_r;

  wvec_t                   x0, x1, xt, xn, xnt;
  logic signed [NRM_W-1:0] cs [3];
  logic signed [WIDE_W-1:0] tp;

  assign pa = {in_item.end_a_z, in_item.end_a_y, in_item.end_a_x};
  assign pb = {in_item.end_b_z, in_item.end_b_y, in_item.end_b_x};
  assign pf = {in_item.opp_first_z, in_item.opp_first_y, in_item.opp_first_x};
  assign ps = {in_item.opp_second_z, in_item.opp_second_y, in_item.opp_second_x};

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      x0[i]  = {{(WIDE_W-DIFF_W){e0_r[i][DIFF_W-1]}}, e0_r[i]};
      x1[i]  = {{(WIDE_W-DIFF_W){e1_r[i][DIFF_W-1]}}, e1_r[i]};
      xt[i]  = {{(WIDE_W-DIFF_W){et_r[i][DIFF_W-1]}}, et_r[i]};
      xn[i]  = {{(WIDE_W-PROD_W){n_r[i][PROD_W-1]}}, n_r[i]};
      xnt[i] = {{(WIDE_W-PROD_W){nt_r[i][PROD_W-1]}}, nt_r[i]};
      cs[i]  = NRM_W'($signed(c_r[i]) >>> SIGN_SHIFT);
    end
    tp = $signed(sp_r[0]) + $signed(sp_r[1]) + $signed(sp_r[2]);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r <= 1'b0;
      vb_r <= 1'b0;
      vc_r <= 1'b0;
      vd_r <= 1'b0;
      ve_r <= 1'b0;
      vf_r <= 1'b0;
      vg_r <= 1'b0;
      vh_r <= 1'b0;
      vi_r <= 1'b0;
    end else if (adv) begin
      va_r <= in_valid;
      vb_r <= va_r;
      vc_r <= vb_r;
      vd_r <= vc_r;
      ve_r <= vd_r;
      vf_r <= ve_r;
      vg_r <= vf_r;
      vh_r <= vg_r;
      vi_r <= vh_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      // edge vectors
      for (int i = 0; i < 3; i++) begin
        e0_r[i] <= $signed(pb[i]) - $signed(pa[i]);
        e1_r[i] <= $signed(pf[i]) - $signed(pb[i]);
        et_r[i] <= $signed(ps[i]) - $signed(pa[i]);
      end
      e0b_r <= edb_block_norm(x0);
      e1b_r <= edb_block_norm(x1);
      etb_r <= edb_block_norm(xt);
      // n = e0 x e1, nt = et x e0
      pn_r[0][0] <= $signed(e0b_r[1]) * $signed(e1b_r[2]);
      pn_r[0][1] <= $signed(e0b_r[2]) * $signed(e1b_r[1]);
      pn_r[1][0] <= $signed(e0b_r[2]) * $signed(e1b_r[0]);
      pn_r[1][1] <= $signed(e0b_r[0]) * $signed(e1b_r[2]);
      pn_r[2][0] <= $signed(e0b_r[0]) * $signed(e1b_r[1]);
      pn_r[2][1] <= $signed(e0b_r[1]) * $signed(e1b_r[0]);
      pt_r[0][0] <= $signed(etb_r[1]) * $signed(e0b_r[2]);
      pt_r[0][1] <= $signed(etb_r[2]) * $signed(e0b_r[1]);
      pt_r[1][0] <= $signed(etb_r[2]) * $signed(e0b_r[0]);
      pt_r[1][1] <= $signed(etb_r[0]) * $signed(e0b_r[2]);
      pt_r[2][0] <= $signed(etb_r[0]) * $signed(e0b_r[1]);
      pt_r[2][1] <= $signed(etb_r[1]) * $signed(e0b_r[0]);
      e0c_r <= e0b_r;
      for (int i = 0; i < 3; i++) begin
        n_r[i]  <= $signed(pn_r[i][0]) - $signed(pn_r[i][1]);
        nt_r[i] <= $signed(pt_r[i][0]) - $signed(pt_r[i][1]);
      end
      e0d_r <= e0c_r;
      nne_r  <= edb_block_norm(xn);
      ntne_r <= edb_block_norm(xnt);
      dge_r  <= (n_r == '0) || (nt_r == '0);
      e0e_r  <= e0d_r;
      // squared lengths and the fold sign cross product
      for (int i = 0; i < 3; i++) begin
        sqn_r[i] <= $signed(nne_r[i]) * $signed(nne_r[i]);
        sqt_r[i] <= $signed(ntne_r[i]) * $signed(ntne_r[i]);
      end
      pc_r[0][0] <= $signed(nne_r[1]) * $signed(ntne_r[2]);
      pc_r[0][1] <= $signed(nne_r[2]) * $signed(ntne_r[1]);
      pc_r[1][0] <= $signed(nne_r[2]) * $signed(ntne_r[0]);
      pc_r[1][1] <= $signed(nne_r[0]) * $signed(ntne_r[2]);
      pc_r[2][0] <= $signed(nne_r[0]) * $signed(ntne_r[1]);
      pc_r[2][1] <= $signed(nne_r[1]) * $signed(ntne_r[0]);
      nnf_r  <= nne_r;
      ntnf_r <= ntne_r;
      dgf_r  <= dge_r;
      e0f_r  <= e0e_r;
      la2g_r <= WIDE_W'(sqn_r[0]) + WIDE_W'(sqn_r[1]) + WIDE_W'(sqn_r[2]);
      lb2g_r <= WIDE_W'(sqt_r[0]) + WIDE_W'(sqt_r[1]) + WIDE_W'(sqt_r[2]);
      for (int i = 0; i < 3; i++) begin
        c_r[i] <= $signed(pc_r[i][0]) - $signed(pc_r[i][1]);
      end
      nng_r  <= nnf_r;
      ntng_r <= ntnf_r;
      dgg_r  <= dgf_r;
      e0g_r  <= e0f_r;
      for (int i = 0; i < 3; i++) begin
        sp_r[i] <= cs[i] * $signed(e0g_r[i]);
      end
      la2h_r <= la2g_r;
      lb2h_r <= lb2g_r;
      nnh_r  <= nng_r;
      ntnh_r <= ntng_r;
      dgh_r  <= dgg_r;
      negi_r <= tp <= 0;
      la2i_r <= la2h_r;
      lb2i_r <= lb2h_r;
      nni_r  <= nnh_r;
      ntni_r <= ntnh_r;
      dgi_r  <= dgh_r;
    end
  end

  assign front.valid = vi_r;
  assign front.nn    = nni_r;
  assign front.ntn   = ntni_r;
  assign front.la2   = la2i_r;
  assign front.lb2   = lb2i_r;
  assign front.degen = dgi_r;
  assign front.neg   = negi_r;

endmodule

@@ rtl/edge_dihedral_bending_core.sv @@
// edge_dihedral_bending_core: top level of the bending measure pipeline
// depends on edb_pkg, edb_in_if, edb_out_if, edb_front, edb_isqrt, edb_div
//
// in_chan takes one interior edge per transfer: both endpoints and the two
// opposite vertices, Q16.16. out_chan returns one result per edge, in order:
// bend_value (Q16.16, twice the signed tangent of half the dihedral angle)
// and bend_status (ok, saturated, degenerate face).
// Throughput is one edge per cycle while out_chan takes results. There are
// 143 register stages, the first loaded at the input transfer, the last driving
// out_chan: nine front stages, two square root pipelines of 32 stages, two divider
// pipelines of 33 stages, three add and square stages and the output register.
// The whole pipeline moves as one: when out_chan holds a result that is
// not taken, every stage holds and in_chan.ready drops; nothing is lost or
// repeated. While the output register is empty or being taken, in_chan stays
// ready. Reset clears all valid bits; there is no other state.
module edge_dihedral_bending_core import edb_pkg::*; (
  input logic      clk,
  input logic      rst_n,
  edb_in_if.sink   in_chan,
  edb_out_if.source out_chan
);

  typedef struct packed {
    logic  valid;
    nvec_t nn;
    nvec_t ntn;
    logic  degen;
    logic  neg;
  } sd1_t;

  typedef struct packed {
    logic       valid;
    logic [2:0] sgn_a;
    logic [2:0] sgn_b;
    logic       degen;
    logic       neg;
  } sd2_t;

  typedef struct packed {
    logic valid;
    logic degen;
    logic neg;
  } sd3_t;

  typedef struct packed {
    logic valid;
    logic degen;
    logic neg;
    logic slz;
  } sd4_t;

  logic     adv;
  in_item_t item;
  front_t   front;

  logic [ROOT_W-1:0] la, lb, dl, sl;
  sd1_t sd1_r [SQRT_STAGES];
  sd2_t sd2_r [DIV_STAGES];
  sd3_t sd3_r [SQRT_STAGES];
  sd4_t sd4_r [DIV_STAGES];

  logic [2:0][WIDE_W-1:0] num_a, num_b;
  logic [2:0][QUO_W-1:0]  quo_a, quo_b;
  logic signed [UA_W-1:0] ua [3];
  logic signed [UA_W-1:0] ub [3];
  logic [UA_W-1:0]        qa [3];
  logic [UA_W-1:0]        qb [3];

  logic                   vk_r, vm_r, vn_r;
  logic                   dgk_r, dgm_r, dgn_r, negk_r, negm_r, negn_r;
  logic [2:0][DIFF_W-1:0] d_r, s_r;
  logic [UA_W-1:0]        ad [3];
  logic [UA_W-1:0]        as [3];
  logic [2:0][WIDE_W-1:0] sqd_r, sqs_r;
  logic [WIDE_W-1:0]      dl2_r, sl2_r;

  logic [WIDE_W-1:0] num_q;
  logic [QUO_W-1:0]  quo_q;
  logic              ovf_q;
  logic              pos_sat, neg_sat;
  logic [VAL_W-1:0]  val_nxt;
  logic [ST_W-1:0]   st_nxt;

  logic              out_valid_r;
  logic [VAL_W-1:0]  out_value_r;
  logic [ST_W-1:0]   out_status_r;

  assign adv           = out_chan.ready || !out_valid_r;
  assign in_chan.ready = adv;

  assign item.end_a_x      = in_chan.end_a_x;
  assign item.end_a_y      = in_chan.end_a_y;
  assign item.end_a_z      = in_chan.end_a_z;
  assign item.end_b_x      = in_chan.end_b_x;
  assign item.end_b_y      = in_chan.end_b_y;
  assign item.end_b_z      = in_chan.end_b_z;
  assign item.opp_first_x  = in_chan.opp_first_x;
  assign item.opp_first_y  = in_chan.opp_first_y;
  assign item.opp_first_z  = in_chan.opp_first_z;
  assign item.opp_second_x = in_chan.opp_second_x;
  assign item.opp_second_y = in_chan.opp_second_y;
  assign item.opp_second_z = in_chan.opp_second_z;

  edb_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .adv      (adv),
    .in_valid (in_chan.valid),
    .in_item  (item),
    .front    (front)
  );

  // normal lengths
  edb_isqrt u_sqrt_la (.clk(clk), .adv(adv), .radicand(front.la2), .root(la));
  edb_isqrt u_sqrt_lb (.clk(clk), .adv(adv), .radicand(front.lb2), .root(lb));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < SQRT_STAGES; k++) sd1_r[k].valid <= 1'b0;
    end else if (adv) begin
      sd1_r[0].valid <= front.valid;
      sd1_r[0].nn    <= front.nn;
      sd1_r[0].ntn   <= front.ntn;
      sd1_r[0].degen <= front.degen;
      sd1_r[0].neg   <= front.neg;
      for (int k = 1; k < SQRT_STAGES; k++) sd1_r[k] <= sd1_r[k-1];
    end
  end

  // unit normals in Q2.30
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      num_a[i] = WIDE_W'(sd1_r[SQRT_STAGES-1].nn[i][NRM_W-1] ?
                         NRM_W'(-sd1_r[SQRT_STAGES-1].nn[i]) :
                         sd1_r[SQRT_STAGES-1].nn[i]) << UNIT_FRAC;
      num_b[i] = WIDE_W'(sd1_r[SQRT_STAGES-1].ntn[i][NRM_W-1] ?
                         NRM_W'(-sd1_r[SQRT_STAGES-1].ntn[i]) :
                         sd1_r[SQRT_STAGES-1].ntn[i]) << UNIT_FRAC;
    end
  end

  for (genvar i = 0; i < 3; i++) begin : g_unit
    edb_div u_div_a (
      .clk (clk), .adv (adv), .num (num_a[i]),
      .den ({1'b0, la}), .quo (quo_a[i]), .ovf ()
    );
    edb_div u_div_b (
      .clk (clk), .adv (adv), .num (num_b[i]),
      .den ({1'b0, lb}), .quo (quo_b[i]), .ovf ()
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < DIV_STAGES; k++) sd2_r[k].valid <= 1'b0;
    end else if (adv) begin
      sd2_r[0].valid <= sd1_r[SQRT_STAGES-1].valid;
      for (int i = 0; i < 3; i++) begin
        sd2_r[0].sgn_a[i] <= sd1_r[SQRT_STAGES-1].nn[i][NRM_W-1];
        sd2_r[0].sgn_b[i] <= sd1_r[SQRT_STAGES-1].ntn[i][NRM_W-1];
      end
      sd2_r[0].degen <= sd1_r[SQRT_STAGES-1].degen;
      sd2_r[0].neg   <= sd1_r[SQRT_STAGES-1].neg;
      for (int k = 1; k < DIV_STAGES; k++) sd2_r[k] <= sd2_r[k-1];
    end
  end

  // difference and sum of the unit normals, then their squared lengths
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      qa[i] = quo_a[i][UA_W-1:0];
      qb[i] = quo_b[i][UA_W-1:0];
      ua[i] = sd2_r[DIV_STAGES-1].sgn_a[i] ? UA_W'(-qa[i]) : qa[i];
      ub[i] = sd2_r[DIV_STAGES-1].sgn_b[i] ? UA_W'(-qb[i]) : qb[i];
      ad[i] = d_r[i][DIFF_W-1] ? UA_W'(-d_r[i]) : d_r[i][UA_W-1:0];
      as[i] = s_r[i][DIFF_W-1] ? UA_W'(-s_r[i]) : s_r[i][UA_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vk_r <= 1'b0;
      vm_r <= 1'b0;
      vn_r <= 1'b0;
    end else if (adv) begin
      vk_r <= sd2_r[DIV_STAGES-1].valid;
      vm_r <= vk_r;
      vn_r <= vm_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        d_r[i]   <= ua[i] - ub[i];
        s_r[i]   <= ua[i] + ub[i];
        sqd_r[i] <= ad[i] * ad[i];
        sqs_r[i] <= as[i] * as[i];
      end
      dgk_r  <= sd2_r[DIV_STAGES-1].degen;
      negk_r <= sd2_r[DIV_STAGES-1].neg;
      dgm_r  <= dgk_r;
      negm_r <= negk_r;
      dl2_r  <= sqd_r[0] + sqd_r[1] + sqd_r[2];
      sl2_r  <= sqs_r[0] + sqs_r[1] + sqs_r[2];
      dgn_r  <= dgm_r;
      negn_r <= negm_r;
    end
  end

  edb_isqrt u_sqrt_dl (.clk(clk), .adv(adv), .radicand(dl2_r), .root(dl));
  edb_isqrt u_sqrt_sl (.clk(clk), .adv(adv), .radicand(sl2_r), .root(sl));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < SQRT_STAGES; k++) sd3_r[k].valid <= 1'b0;
    end else if (adv) begin
      sd3_r[0].valid <= vn_r;
      sd3_r[0].degen <= dgn_r;
      sd3_r[0].neg   <= negn_r;
      for (int k = 1; k < SQRT_STAGES; k++) sd3_r[k] <= sd3_r[k-1];
    end
  end

  // magnitude 2 * dl / sl in Q16.16
  assign num_q = WIDE_W'(dl) << Q_SHIFT;

  edb_div u_div_q (
    .clk (clk), .adv (adv), .num (num_q),
    .den ({1'b0, sl}), .quo (quo_q), .ovf (ovf_q)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < DIV_STAGES; k++) sd4_r[k].valid <= 1'b0;
    end else if (adv) begin
      sd4_r[0].valid <= sd3_r[SQRT_STAGES-1].valid;
      sd4_r[0].degen <= sd3_r[SQRT_STAGES-1].degen;
      sd4_r[0].neg   <= sd3_r[SQRT_STAGES-1].neg;
      sd4_r[0].slz   <= sl == '0;
      for (int k = 1; k < DIV_STAGES; k++) sd4_r[k] <= sd4_r[k-1];
    end
  end

  // sign, saturation and status
  always_comb begin
    pos_sat = ovf_q || (quo_q[QUO_W-1:VAL_W-1] != '0);
    neg_sat = ovf_q || (quo_q > {{(QUO_W-VAL_W){1'b0}}, VAL_MIN});
    val_nxt = '0;
    st_nxt  = ST_OK;
    if (sd4_r[DIV_STAGES-1].degen) begin
      val_nxt = '0;
      st_nxt  = ST_DEGEN;
    end else if (sd4_r[DIV_STAGES-1].slz) begin
      val_nxt = sd4_r[DIV_STAGES-1].neg ? VAL_MIN : VAL_MAX;
      st_nxt  = ST_SAT;
    end else if (!sd4_r[DIV_STAGES-1].neg) begin
      val_nxt = pos_sat ? VAL_MAX : quo_q[VAL_W-1:0];
      st_nxt  = pos_sat ? ST_SAT : ST_OK;
    end else begin
      val_nxt = neg_sat ? VAL_MIN : VAL_W'(-quo_q[VAL_W-1:0]);
      st_nxt  = neg_sat ? ST_SAT : ST_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= sd4_r[DIV_STAGES-1].valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_value_r  <= val_nxt;
      out_status_r <= st_nxt;
    end
  end

  assign out_chan.valid       = out_valid_r;
  assign out_chan.bend_value  = out_value_r;
  assign out_chan.bend_status = out_status_r;

endmodule
